@@ rtl/tnnc_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-nearest-neighbour cosine: shared package
// Types, widths, status codes and sequencer states used by the block and its
// checker.
// ----------------------------------------------------------------------------
package tnnc_pkg;

  // Sizes of the point store and the coordinate format.
  localparam int MaxPoints = 64;
  localparam int CoordBits = 24;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;
  localparam int PointW    = 2 * CoordBits;

  // Arithmetic widths: difference, squared length, product of two lengths.
  localparam int DiffW = CoordBits + 1;
  localparam int DistW = 2 * DiffW + 1;
  localparam int ProdW = 2 * DistW;
  localparam int LoW   = 15;
  localparam int T2W   = 2 * LoW;
  localparam int AccW  = ProdW + T2W;
  localparam int MulBW = DistW;

  // Cosine format, Q1.14.
  localparam int CosW = 16;
  localparam logic [LoW-1:0] OneQ14 = LoW'(16384);
  localparam logic [CntW-1:0] MinPoints = CntW'(3);

  // Result status codes.
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusDegen  = 2'd1;
  localparam logic [1:0] StatusTooFew = 2'd2;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic                        final_point;
  } point_t;

  typedef struct packed {
    logic [IdxW-1:0]        point_index;
    logic signed [CosW-1:0] cosine;
    logic [1:0]             status;
    logic                   last_result;
  } result_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_KRD,
    S_KDAT,
    S_ORD,
    S_ODAT,
    S_SQX,
    S_SQY,
    S_DOT1,
    S_DOT1W,
    S_DOT2W,
    S_DOTS,
    S_MPW,
    S_MRW,
    S_BST,
    S_BSTW,
    S_BSPW,
    S_EMIT
  } state_e;

  // Magnitude of a signed difference.
  function automatic logic [DiffW-1:0] mag_diff(input logic signed [DiffW-1:0] v);
    logic [DiffW-1:0] r;
    r = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
    return r;
  endfunction

endpackage

@@ rtl/tnnc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module tnnc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/two_nearest_neighbor_cosine_top.sv @@
// ----------------------------------------------------------------------------
// Two-nearest-neighbour cosine: top level
// Stores a point set and, on the final point, gives for every point the
// cosine of the angle between the vectors to its two nearest neighbours.
//
//   Channel   Direction  Transfer when                Payload
//   -------   ---------  ---------------------------  ----------
//   point     in         start high and busy low      point_i
//   result    out        result_valid_o high (1 cyc)  result_o
//
// A non-final point keeps busy low. A final point with n >= 3 points keeps
// busy high for the neighbour walk and the cosine search of every point.
// Both run on the shared shift-add multiplier, which retires one multiplier
// bit per cycle. Fewer than three points give one result in the cycle after
// the transfer. Reset needs no clearing pass.
// Results cannot be stalled: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module two_nearest_neighbor_cosine_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tnnc_pkg::point_t point_i,
  output logic             result_valid_o,
  output tnnc_pkg::result_t result_o
);

  localparam int IdxW  = tnnc_pkg::IdxW;
  localparam int CntW  = tnnc_pkg::CntW;
  localparam int CrdW  = tnnc_pkg::CoordBits;
  localparam int DiffW = tnnc_pkg::DiffW;
  localparam int DistW = tnnc_pkg::DistW;
  localparam int ProdW = tnnc_pkg::ProdW;
  localparam int AccW  = tnnc_pkg::AccW;
  localparam int MulBW = tnnc_pkg::MulBW;
  localparam int LoW   = tnnc_pkg::LoW;
  localparam int T2W   = tnnc_pkg::T2W;
  localparam int CosW  = tnnc_pkg::CosW;

  tnnc_pkg::state_e state_q, state_d;

  // Load counter and evaluation indexes.
  logic [CntW-1:0] count_q, count_d, n_q, n_d, o_q, o_d;
  logic [IdxW-1:0] k_q, k_d;

  // Centre point, current difference and the two best neighbours.
  logic signed [CrdW-1:0]  kx_q, kx_d, ky_q, ky_d;
  logic signed [DiffW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [DiffW-1:0] v1x_q, v1x_d, v1y_q, v1y_d, v2x_q, v2x_d, v2y_q, v2y_d;
  logic [DistW-1:0]        d1_q, d1_d, d2_q, d2_d;
  logic                    h1_q, h1_d, h2_q, h2_d, deg_q, deg_d;

  // Cosine search operands.
  logic [DistW-1:0] p1_q, p1_d, dmag_q, dmag_d;
  logic             dneg_q, dneg_d;
  logic [ProdW-1:0] prod_q, prod_d, rhs_q, rhs_d;
  logic [LoW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  // Search step phase and its compare.
  logic bs_phase_q, bs_phase_d;
  logic bs_le;

  // Shared shift-add multiplier.
  logic [AccW-1:0]  ma_q, ma_d, macc_q, macc_d;
  logic [MulBW-1:0] mb_q, mb_d;
  logic             mrun_q, mrun_d;
  logic             mul_go, mul_keep;
  logic [AccW-1:0]  mul_a;
  logic [MulBW-1:0] mul_b;

  // Result register.
  logic              res_valid_q, res_valid_d;
  tnnc_pkg::result_t res_q, res_d;

  // Store interface.
  logic                           accept, store_we;
  logic [CntW-1:0]                n_new;
  logic [IdxW-1:0]                raddr;
  logic [tnnc_pkg::PointW-1:0]    rdata;
  logic signed [CrdW-1:0]         rd_x, rd_y;
  logic signed [DiffW-1:0]        cur_dx, cur_dy;
  logic [DistW-1:0]               sq_len;
  logic signed [DistW+1:0]        term1, term2, dot;
  logic [LoW:0]                   mid_sum;
  logic [LoW-1:0]                 tval;

  assign accept   = start && !busy;
  assign store_we = accept && (count_q != CntW'(tnnc_pkg::MaxPoints));
  assign n_new    = store_we ? count_q + CntW'(1) : count_q;
  assign busy     = (state_q != tnnc_pkg::S_IDLE);

  assign rd_x   = rdata[tnnc_pkg::PointW-1:CrdW];
  assign rd_y   = rdata[CrdW-1:0];
  assign cur_dx = DiffW'(rd_x) - DiffW'(kx_q);
  assign cur_dy = DiffW'(rd_y) - DiffW'(ky_q);
  assign sq_len = macc_q[DistW-1:0];
  assign bs_le  = (macc_q <= {rhs_q, T2W'(0)});

  // Point store, x in the upper half and y in the lower half.
  tnnc_ram #(
    .Width(tnnc_pkg::PointW),
    .Depth(tnnc_pkg::MaxPoints)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i({point_i.point_x, point_i.point_y}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tnnc_pkg::S_IDLE: begin
        if (accept && point_i.final_point && n_new >= tnnc_pkg::MinPoints) begin
          state_d = tnnc_pkg::S_KRD;
        end
      end
      tnnc_pkg::S_KRD:  state_d = tnnc_pkg::S_KDAT;
      tnnc_pkg::S_KDAT: state_d = tnnc_pkg::S_ORD;
      tnnc_pkg::S_ORD: begin
        if (o_q != n_q) begin
          state_d = tnnc_pkg::S_ODAT;
        end else if (d1_q == '0 || d2_q == '0) begin
          state_d = tnnc_pkg::S_EMIT;
        end else begin
          state_d = tnnc_pkg::S_DOT1;
        end
      end
      tnnc_pkg::S_ODAT: begin
        state_d = (o_q[IdxW-1:0] == k_q) ? tnnc_pkg::S_ORD : tnnc_pkg::S_SQX;
      end
      tnnc_pkg::S_SQX:   if (!mrun_q) state_d = tnnc_pkg::S_SQY;
      tnnc_pkg::S_SQY:   if (!mrun_q) state_d = tnnc_pkg::S_ORD;
      tnnc_pkg::S_DOT1:  state_d = tnnc_pkg::S_DOT1W;
      tnnc_pkg::S_DOT1W: if (!mrun_q) state_d = tnnc_pkg::S_DOT2W;
      tnnc_pkg::S_DOT2W: if (!mrun_q) state_d = tnnc_pkg::S_DOTS;
      tnnc_pkg::S_DOTS:  state_d = tnnc_pkg::S_MPW;
      tnnc_pkg::S_MPW:   if (!mrun_q) state_d = tnnc_pkg::S_MRW;
      tnnc_pkg::S_MRW:   if (!mrun_q) state_d = tnnc_pkg::S_BST;
      tnnc_pkg::S_BST: begin
        state_d = (lo_q >= hi_q) ? tnnc_pkg::S_EMIT : tnnc_pkg::S_BSTW;
      end
      tnnc_pkg::S_BSTW:  if (!mrun_q) state_d = tnnc_pkg::S_BSPW;
      tnnc_pkg::S_BSPW:  if (!mrun_q && bs_phase_q) state_d = tnnc_pkg::S_BST;
      tnnc_pkg::S_EMIT: begin
        state_d = (CntW'(k_q) + CntW'(1) == n_q) ? tnnc_pkg::S_IDLE : tnnc_pkg::S_KRD;
      end
      default: state_d = tnnc_pkg::S_IDLE;
    endcase
  end

  // Output and datapath logic of the sequencer.
  always_comb begin
    count_d = count_q;  n_d = n_q;  o_d = o_q;  k_d = k_q;
    kx_d = kx_q;  ky_d = ky_q;  dx_d = dx_q;  dy_d = dy_q;
    v1x_d = v1x_q;  v1y_d = v1y_q;  v2x_d = v2x_q;  v2y_d = v2y_q;
    d1_d = d1_q;  d2_d = d2_q;  h1_d = h1_q;  h2_d = h2_q;  deg_d = deg_q;
    p1_d = p1_q;  dmag_d = dmag_q;  dneg_d = dneg_q;
    prod_d = prod_q;  rhs_d = rhs_q;
    lo_d = lo_q;  hi_d = hi_q;  mid_d = mid_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    raddr       = k_q;
    mul_go      = 1'b0;
    mul_keep    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    term1       = '0;
    term2       = '0;
    dot         = '0;
    mid_sum     = (LoW+1)'(lo_q) + (LoW+1)'(hi_q) + (LoW+1)'(1);
    tval        = LoW'({mid_q, 1'b0} - (LoW+1)'(1));

    unique case (state_q)
      tnnc_pkg::S_IDLE: begin
        if (accept) begin
          if (point_i.final_point) begin
            n_d     = n_new;
            count_d = '0;
            k_d     = '0;
            if (n_new < tnnc_pkg::MinPoints) begin
              res_valid_d       = 1'b1;
              res_d.point_index = '0;
              res_d.cosine      = '0;
              res_d.status      = tnnc_pkg::StatusTooFew;
              res_d.last_result = 1'b1;
            end
          end else begin
            count_d = n_new;
          end
        end
      end
      tnnc_pkg::S_KRD: raddr = k_q;
      tnnc_pkg::S_KDAT: begin
        kx_d = rd_x;
        ky_d = rd_y;
        o_d  = '0;
        h1_d = 1'b0;
        h2_d = 1'b0;
      end
      tnnc_pkg::S_ORD: begin
        raddr = o_q[IdxW-1:0];
        deg_d = (d1_q == '0 || d2_q == '0);
        lo_d  = '0;
      end
      tnnc_pkg::S_ODAT: begin
        if (o_q[IdxW-1:0] == k_q) begin
          o_d = o_q + CntW'(1);
        end else begin
          dx_d   = cur_dx;
          dy_d   = cur_dy;
          mul_go = 1'b1;
          mul_a  = AccW'(tnnc_pkg::mag_diff(cur_dx));
          mul_b  = MulBW'(tnnc_pkg::mag_diff(cur_dx));
        end
      end
      tnnc_pkg::S_SQX: begin
        if (!mrun_q) begin
          mul_go   = 1'b1;
          mul_keep = 1'b1;
          mul_a    = AccW'(tnnc_pkg::mag_diff(dy_q));
          mul_b    = MulBW'(tnnc_pkg::mag_diff(dy_q));
        end
      end
      tnnc_pkg::S_SQY: begin
        // Strict less-than keeps the earlier point on a tie.
        if (!mrun_q) begin
          o_d = o_q + CntW'(1);
          if (!h1_q || sq_len < d1_q) begin
            d2_d = d1_q;    v2x_d = v1x_q;  v2y_d = v1y_q;  h2_d = h1_q;
            d1_d = sq_len;  v1x_d = dx_q;   v1y_d = dy_q;   h1_d = 1'b1;
          end else if (!h2_q || sq_len < d2_q) begin
            d2_d = sq_len;  v2x_d = dx_q;   v2y_d = dy_q;   h2_d = 1'b1;
          end
        end
      end
      tnnc_pkg::S_DOT1: begin
        mul_go = 1'b1;
        mul_a  = AccW'(tnnc_pkg::mag_diff(v1x_q));
        mul_b  = MulBW'(tnnc_pkg::mag_diff(v2x_q));
      end
      tnnc_pkg::S_DOT1W: begin
        if (!mrun_q) begin
          p1_d   = macc_q[DistW-1:0];
          mul_go = 1'b1;
          mul_a  = AccW'(tnnc_pkg::mag_diff(v1y_q));
          mul_b  = MulBW'(tnnc_pkg::mag_diff(v2y_q));
        end
      end
      tnnc_pkg::S_DOT2W: begin
        if (!mrun_q) begin
          dmag_d = macc_q[DistW-1:0];
        end
      end
      tnnc_pkg::S_DOTS: begin
        // Signed dot product from the two magnitudes.
        term1  = (v1x_q[DiffW-1] ^ v2x_q[DiffW-1]) ? -(DistW+2)'(p1_q) : (DistW+2)'(p1_q);
        term2  = (v1y_q[DiffW-1] ^ v2y_q[DiffW-1]) ? -(DistW+2)'(dmag_q)
                                                   : (DistW+2)'(dmag_q);
        dot    = term1 + term2;
        dneg_d = dot[DistW+1];
        dmag_d = dot[DistW+1] ? DistW'(-dot) : DistW'(dot);
        mul_go = 1'b1;
        mul_a  = AccW'(d1_q);
        mul_b  = MulBW'(d2_q);
      end
      tnnc_pkg::S_MPW: begin
        if (!mrun_q) begin
          prod_d = macc_q[ProdW-1:0];
          mul_go = 1'b1;
          mul_a  = AccW'(dmag_q);
          mul_b  = MulBW'(dmag_q);
        end
      end
      tnnc_pkg::S_MRW: begin
        if (!mrun_q) begin
          rhs_d = macc_q[ProdW-1:0];
          lo_d  = '0;
          hi_d  = tnnc_pkg::OneQ14;
        end
      end
      tnnc_pkg::S_BST: begin
        if (lo_q < hi_q) begin
          mid_d = mid_sum[LoW:1];
        end
      end
      tnnc_pkg::S_BSTW: begin
        if (!mrun_q) begin
          mul_go = 1'b1;
          mul_a  = AccW'(tval);
          mul_b  = MulBW'(tval);
        end
      end
      tnnc_pkg::S_BSPW: begin
        // The first completion is t*t, the second is t*t times the length
        // product, which decides the search step.
        if (!mrun_q) begin
          if (!bs_phase_q) begin
            mul_go = 1'b1;
            mul_a  = AccW'(prod_q);
            mul_b  = MulBW'(macc_q[T2W-1:0]);
          end else if (bs_le) begin
            lo_d = mid_q;
          end else begin
            hi_d = mid_q - LoW'(1);
          end
        end
      end
      tnnc_pkg::S_EMIT: begin
        res_valid_d       = 1'b1;
        res_d.point_index = k_q;
        res_d.status      = deg_q ? tnnc_pkg::StatusDegen : tnnc_pkg::StatusOk;
        res_d.cosine      = (deg_q || !dneg_q) ? CosW'(lo_q) : -CosW'(lo_q);
        res_d.last_result = (CntW'(k_q) + CntW'(1) == n_q);
        k_d               = k_q + IdxW'(1);
      end
      default: ;
    endcase
  end

  // Phase of the search step: low while t*t runs, high while the long
  // product runs.
  always_comb begin
    bs_phase_d = bs_phase_q;
    if (state_q == tnnc_pkg::S_BSTW && !mrun_q) begin
      bs_phase_d = 1'b0;
    end else if (state_q == tnnc_pkg::S_BSPW && !mrun_q) begin
      bs_phase_d = !bs_phase_q;
    end
  end

  // Shift-add multiplier: one bit of the multiplier operand per cycle.
  always_comb begin
    ma_d   = ma_q;
    mb_d   = mb_q;
    macc_d = macc_q;
    mrun_d = mrun_q;
    if (mul_go) begin
      ma_d   = mul_a;
      mb_d   = mul_b;
      macc_d = mul_keep ? macc_q : '0;
      mrun_d = 1'b1;
    end else if (mrun_q) begin
      if (mb_q == '0) begin
        mrun_d = 1'b0;
      end else begin
        if (mb_q[0]) begin
          macc_d = macc_q + ma_q;
        end
        ma_d = ma_q << 1;
        mb_d = mb_q >> 1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnnc_pkg::S_IDLE;
      count_q     <= '0;
      mrun_q      <= 1'b0;
      res_valid_q <= 1'b0;
      bs_phase_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mrun_q      <= mrun_d;
      res_valid_q <= res_valid_d;
      bs_phase_q  <= bs_phase_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    n_q <= n_d;  o_q <= o_d;  k_q <= k_d;
    kx_q <= kx_d;  ky_q <= ky_d;  dx_q <= dx_d;  dy_q <= dy_d;
    v1x_q <= v1x_d;  v1y_q <= v1y_d;  v2x_q <= v2x_d;  v2y_q <= v2y_d;
    d1_q <= d1_d;  d2_q <= d2_d;  h1_q <= h1_d;  h2_q <= h2_d;  deg_q <= deg_d;
    p1_q <= p1_d;  dmag_q <= dmag_d;  dneg_q <= dneg_d;
    prod_q <= prod_d;  rhs_q <= rhs_d;
    hi_q <= hi_d;  mid_q <= mid_d;
    lo_q <= lo_d;
    ma_q <= ma_d;  mb_q <= mb_d;  macc_q <= macc_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

@@ rtl/tnnc_checker.sv @@
// ----------------------------------------------------------------------------
// Two-nearest-neighbour cosine: port checker
// Watches the ports of the top level and checks results over time.
// ----------------------------------------------------------------------------
module tnnc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input tnnc_pkg::point_t  point_i,
  input logic              result_valid_o,
  input tnnc_pkg::result_t result_o
);

  // A result that is not the last of its set is followed by more work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_result |=> busy)
    else $error("busy dropped before the last result");

  // A too-few result is the whole, empty answer for its set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status == tnnc_pkg::StatusTooFew |->
      result_o.last_result && result_o.cosine == '0 && result_o.point_index == '0)
    else $error("malformed too-few result");

  // A non-final point never causes a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !point_i.final_point |=> !result_valid_o)
    else $error("result after a non-final point");

  // The cosine stays within minus one to one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.cosine <= 16'sd16384 && result_o.cosine >= -16'sd16384)
    else $error("cosine out of range");

endmodule

bind two_nearest_neighbor_cosine_top tnnc_checker u_tnnc_checker (.*);

@@ tb/tb_two_nearest_neighbor_cosine_top.sv @@
// ----------------------------------------------------------------------------
// Two-nearest-neighbour cosine: self-checking testbench
// Loads point sets through the start/busy port with random gaps and compares
// every result strobe with a cosine predicted in exact wide integer
// arithmetic. The sets cover fewer than three points, coincident points,
// extreme coordinates and a store that overflows.
// ----------------------------------------------------------------------------
module tb_two_nearest_neighbor_cosine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 4000000;
  localparam int     SettleCycles = 50;
  localparam int     CoordBits = tnnc_pkg::CoordBits;
  localparam int     MaxPoints = tnnc_pkg::MaxPoints;
  localparam int     IdxW      = tnnc_pkg::IdxW;
  localparam int     CosW      = tnnc_pkg::CosW;

  typedef struct {
    tnnc_pkg::point_t pt;
    int               gap;
    bit               drain;
  } load_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  tnnc_pkg::point_t  point_i;
  logic              result_valid_o;
  tnnc_pkg::result_t result_o;

  two_nearest_neighbor_cosine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .point_i       (point_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Items waiting to be sent, and the cosine results still to arrive.
  load_item_t        pending_points[$];
  tnnc_pkg::result_t expected_cosines[$];

  // Own copy of the point store.
  logic signed [CoordBits-1:0] set_x[MaxPoints];
  logic signed [CoordBits-1:0] set_y[MaxPoints];
  int     set_count = 0;
  int     mismatches = 0;
  longint cycles = 0;
  int     wait_cnt;
  bit     burst_mode;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Exact cosine in Q1.14, rounded half away from zero, by bisection.
  function automatic int cosine_of(longint dot, longint m1, longint m2);
    logic [191:0] prod;
    logic [191:0] rhs;
    logic [191:0] mag;
    logic [191:0] t;
    int lo;
    int hi;
    int mid;
    mag  = (dot < 0) ? -dot : dot;
    prod = 192'(m1) * 192'(m2);
    rhs  = (mag * mag) << 30;
    lo   = 0;
    hi   = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = 192'(2 * mid - 1);
      if (t * t * prod <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (dot < 0) ? -lo : lo;
  endfunction

  // Store an accepted point and, on the final mark, predict the whole set.
  task automatic take_point(input tnnc_pkg::point_t p);
    int n;
    int i1;
    int i2;
    bit h1;
    bit h2;
    longint d;
    longint d1;
    longint d2;
    longint kx;
    longint ky;
    longint vix;
    longint viy;
    longint vjx;
    longint vjy;
    tnnc_pkg::result_t r;
    if (set_count < MaxPoints) begin
      set_x[set_count] = p.point_x;
      set_y[set_count] = p.point_y;
      set_count++;
    end
    if (!p.final_point) return;
    n = set_count;
    set_count = 0;
    if (n < 3) begin
      r.point_index = '0;
      r.cosine      = '0;
      r.status      = tnnc_pkg::StatusTooFew;
      r.last_result = 1'b1;
      expected_cosines = {expected_cosines, r};
      return;
    end
    for (int k = 0; k < n; k++) begin
      kx = set_x[k];
      ky = set_y[k];
      h1 = 0; h2 = 0; i1 = 0; i2 = 0; d1 = 0; d2 = 0;
      // Earlier points win ties since only a strictly smaller distance replaces.
      for (int o = 0; o < n; o++) begin
        if (o == k) continue;
        d = (set_x[o] - kx) * (set_x[o] - kx) + (set_y[o] - ky) * (set_y[o] - ky);
        if (!h1 || d < d1) begin
          d2 = d1; i2 = i1; h2 = h1;
          d1 = d;  i1 = o;  h1 = 1;
        end else if (!h2 || d < d2) begin
          d2 = d; i2 = o; h2 = 1;
        end
      end
      vix = set_x[i1] - kx;
      viy = set_y[i1] - ky;
      vjx = set_x[i2] - kx;
      vjy = set_y[i2] - ky;
      r.point_index = IdxW'(k);
      r.last_result = (k + 1 == n);
      if (d1 == 0 || d2 == 0) begin
        r.status = tnnc_pkg::StatusDegen;
        r.cosine = '0;
      end else begin
        r.status = tnnc_pkg::StatusOk;
        r.cosine = CosW'(cosine_of(vix * vjx + viy * vjy, d1, d2));
      end
      expected_cosines = {expected_cosines, r};
    end
  endtask

  // Driver: one transfer per start-high, busy-low edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      point_i <= '0;
      wait_cnt = 0;
    end else if (start && busy) begin
      // Hold the offered point until it is taken.
    end else begin
      if (start) take_point(point_i);
      if (pending_points.size() != 0 && wait_cnt >= pending_points[0].gap &&
          (!pending_points[0].drain || expected_cosines.size() == 0)) begin
        start   <= 1'b1;
        point_i <= pending_points[0].pt;
        void'(pending_points.pop_front());
        wait_cnt = 0;
      end else begin
        start <= 1'b0;
        if (pending_points.size() != 0 && wait_cnt < pending_points[0].gap) wait_cnt++;
      end
    end
  end

  // Monitor: every strobe must match the oldest expected result.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_cosines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", result_o);
      end else begin
        tnnc_pkg::result_t e;
        e = expected_cosines.pop_front();
        if (e.point_index !== result_o.point_index || e.cosine !== result_o.cosine ||
            e.status !== result_o.status || e.last_result !== result_o.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch idx/cos/st/last: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     e.point_index, e.cosine, e.status, e.last_result,
                     result_o.point_index, result_o.cosine, result_o.status,
                     result_o.last_result);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("two_nearest_neighbor_cosine_top test failed");
      $finish;
    end
  end

  task automatic add_point(input int x, input int y, input bit fin, input bit drain = 0);
    load_item_t it;
    it.pt.point_x     = CoordBits'(x);
    it.pt.point_y     = CoordBits'(y);
    it.pt.final_point = fin;
    it.gap   = burst_mode ? 0 : $urandom_range(0, 9);
    it.drain = drain;
    pending_points = {pending_points, it};
  endtask

  function automatic int rand_coord(input bit wide);
    if (wide) return int'($signed(CoordBits'($urandom)));
    return $urandom_range(0, 8) - 4;
  endfunction

  initial begin
    int n;
    int sent;
    bit wide;
    rst_ni     = 1'b0;
    burst_mode = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed sets: too few points, extremes, straight lines, coincident points.
    add_point(0, 0, 1);
    add_point(-8388608, 8388607, 0);
    add_point(8388607, -8388608, 1);
    add_point(-8388608, -8388608, 0);
    add_point(8388607, 8388607, 0);
    add_point(0, 0, 1, 1);
    add_point(0, 0, 0);
    add_point(256, 0, 0);
    add_point(-512, 0, 1);
    add_point(0, 0, 0);
    add_point(256, 0, 0);
    add_point(512, 0, 1);
    add_point(5, 5, 0);
    add_point(5, 5, 0);
    add_point(-3, 7, 0);
    add_point(1, 1, 1);
    add_point(0, 0, 0);
    add_point(1, 0, 0);
    add_point(0, 1, 0);
    add_point(-1, 0, 0);
    add_point(0, -1, 1);

    // Overflowing set: the final mark rides on a dropped point.
    burst_mode = 1;
    for (int i = 0; i < 66; i++) add_point(rand_coord(0), rand_coord(0), i == 65);

    // Random sets, mostly small, some with full-range coordinates.
    sent = 0;
    while (sent < 40) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      wide = $urandom_range(0, 1);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++)
        add_point(rand_coord(wide), rand_coord(wide), i == n - 1,
                  i == 0 && $urandom_range(0, 3) == 0);
      sent += n;
    end
    // A last set of three full-range points.
    add_point(rand_coord(1), rand_coord(1), 0);
    add_point(rand_coord(1), rand_coord(1), 0);
    add_point(rand_coord(1), rand_coord(1), 1);

    // Sample mid-cycle until every item is sent and every result is back.
    do begin
      @(negedge clk_i);
    end while (pending_points.size() != 0 || start || busy ||
               expected_cosines.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_cosines.size() == 0) begin
      $display("two_nearest_neighbor_cosine_top test passed");
    end else begin
      $display("two_nearest_neighbor_cosine_top test failed");
    end
    $finish;
  end

endmodule
